@@ design/gww_pkg.sv @@
// Package for the greedy word wrap unit: payload types, codes, limits and helpers.
`default_nettype none

package gww_pkg;

	localparam int MaxWidth   = 255;
	localparam int MaxTextLen = 65536;

	localparam logic [16:0] TextCap  = (MaxTextLen - 1 > 65535) ? 17'd65535
		: 17'(MaxTextLen - 1);
	localparam logic [16:0] LinesCap = 17'd65536;

	localparam logic [7:0] ChNewline    = 8'd10;
	localparam logic [7:0] ChSpace      = 8'd32;
	localparam logic [7:0] BoxWidthRst  = 8'd70;
	localparam logic [7:0] FillMax      = 8'd255;

	localparam int QueueDepth = 3;

	typedef enum logic {
		KindLine    = 1'b0,
		KindSummary = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} gww_in_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [15:0] line_start;
		logic [7:0]  line_length;
		logic [16:0] line_total;
		logic        last_result;
	} gww_out_t;

	typedef struct packed {
		logic [1:0] n;
		gww_out_t   r0;
		gww_out_t   r1;
	} gww_push_t;

	function automatic logic [15:0] sat_pos(logic [15:0] a, logic [8:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {8'b0, b};
		return (s > TextCap) ? TextCap[15:0] : s[15:0];
	endfunction

	function automatic logic [7:0] clamp_width(logic [7:0] w);
		logic [7:0] c;
		c = (w == 8'd0) ? 8'd1 : w;
		return (32'(c) > MaxWidth) ? 8'(MaxWidth) : c;
	endfunction

	function automatic gww_out_t mk_line(logic [15:0] start, logic [7:0] len, logic last);
		gww_out_t r;
		r.result_kind = KindLine;
		r.line_start  = start;
		r.line_length = len;
		r.line_total  = 17'd0;
		r.last_result = last;
		return r;
	endfunction

	function automatic gww_out_t mk_summary(logic [16:0] total);
		gww_out_t r;
		r.result_kind = KindSummary;
		r.line_start  = 16'd0;
		r.line_length = 8'd0;
		r.line_total  = total;
		r.last_result = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/greedy_word_wrap_unit.sv @@
// Greedy word wrap unit top level: input channel, config write, result channel.
// Results of an accepted transaction are written into the result queue and presented from its head.
// One character is accepted per cycle while char_stall is low; an end transaction with a
// tail line puts out two results, the line and then the summary.
// char_stall is high while two or more results wait in the three-entry queue.
// Reset clears the line state and the queue and sets box width to 70.
`default_nettype none

module greedy_word_wrap_unit import gww_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       char_valid,
	output logic            char_stall,
	input  wire gww_in_t    char_data,
	output logic            line_valid,
	input  wire logic       line_stall,
	output gww_out_t        line_data
);

	gww_push_t push;
	logic      room_for_two;
	logic      accept;
	logic      pop;

	assign char_stall = !room_for_two;
	assign accept     = char_valid && room_for_two;
	assign pop        = line_valid && !line_stall;

	gww_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (char_data),
		.push      (push)
	);

	gww_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.pop          (pop),
		.head         (line_data),
		.nonempty     (line_valid),
		.room_for_two (room_for_two)
	);

endmodule

`default_nettype wire

@@ design/gww_core.sv @@
// Line breaking state and per-transaction next-state and result logic.
`default_nettype none

module gww_core import gww_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic      accept,
	input  wire gww_in_t   item,
	output gww_push_t      push
);

	logic [7:0]  box_width_q;
	logic [15:0] pos_q;
	logic [15:0] begin_q;
	logic [7:0]  fill_q;
	logic        seen_q;
	logic [7:0]  at_q;
	logic [16:0] lines_q;

	logic [15:0] pos_d;
	logic [15:0] begin_d;
	logic [7:0]  fill_d;
	logic        seen_d;
	logic [7:0]  at_d;
	logic [16:0] lines_d;

	always_comb begin
		logic [7:0]  w;
		logic        nl;
		logic        sp;
		logic        full;
		logic        brk_sp;
		logic [8:0]  adv;
		logic [7:0]  brk_len;
		logic [8:0]  fill_sub;
		logic [7:0]  fill_b;
		logic [15:0] begin_b;
		logic        seen_b;
		logic [7:0]  at_b;
		logic [16:0] lines_inc;
		logic        emit;
		logic        tail;

		w         = clamp_width(box_width_q);
		nl        = (item.character == ChNewline);
		sp        = (item.character == ChSpace);
		full      = !nl && (fill_q >= w);
		brk_sp    = seen_q && (at_q != 8'd0);
		adv       = brk_sp ? ({1'b0, at_q} + 9'd1) : {1'b0, w};
		brk_len   = brk_sp ? at_q : w;
		fill_sub  = {1'b0, fill_q} - adv;
		fill_b    = full ? fill_sub[7:0] : fill_q;
		begin_b   = full ? sat_pos(begin_q, adv) : begin_q;
		seen_b    = full ? 1'b0 : seen_q;
		at_b      = full ? 8'd0 : at_q;
		lines_inc = (lines_q == LinesCap) ? lines_q : lines_q + 17'd1;
		emit      = full || nl;
		tail      = (fill_q != 8'd0) || (lines_q == 17'd0);

		pos_d   = pos_q;
		begin_d = begin_q;
		fill_d  = fill_q;
		seen_d  = seen_q;
		at_d    = at_q;
		lines_d = lines_q;
		push.n  = 2'd0;
		push.r0 = mk_line(begin_q, nl ? fill_q : brk_len, 1'b1);
		push.r1 = mk_summary(tail ? lines_inc : lines_q);

		if (accept) begin
			if (item.end_of_text) begin
				pos_d   = 16'd0;
				begin_d = 16'd0;
				fill_d  = 8'd0;
				seen_d  = 1'b0;
				at_d    = 8'd0;
				lines_d = 17'd0;
				if (tail) begin
					push.n  = 2'd2;
					push.r0 = mk_line(begin_q, fill_q, 1'b0);
				end else begin
					push.n  = 2'd1;
					push.r0 = mk_summary(lines_q);
				end
			end else begin
				pos_d   = sat_pos(pos_q, 9'd1);
				push.n  = emit ? 2'd1 : 2'd0;
				lines_d = emit ? lines_inc : lines_q;
				if (nl) begin
					begin_d = sat_pos(pos_q, 9'd1);
					fill_d  = 8'd0;
					seen_d  = 1'b0;
					at_d    = 8'd0;
				end else begin
					begin_d = begin_b;
					fill_d  = (fill_b == FillMax) ? FillMax : fill_b + 8'd1;
					seen_d  = sp ? 1'b1 : seen_b;
					at_d    = sp ? fill_b : at_b;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_width_q <= BoxWidthRst;
			pos_q       <= 16'd0;
			begin_q     <= 16'd0;
			fill_q      <= 8'd0;
			seen_q      <= 1'b0;
			at_q        <= 8'd0;
			lines_q     <= 17'd0;
		end else begin
			if (cfg_we) begin
				box_width_q <= cfg_wdata;
			end
			pos_q   <= pos_d;
			begin_q <= begin_d;
			fill_q  <= fill_d;
			seen_q  <= seen_d;
			at_q    <= at_d;
			lines_q <= lines_d;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.end_of_text |=> pos_q == 16'd0 && lines_q == 17'd0 && fill_q == 8'd0)
		else $error("end transaction did not clear line state");

	a_char_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.end_of_text |-> push.n == 2'd0 || push.n == 2'd1)
		else $error("character transaction produced more than one line");

	a_end_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.end_of_text |->
			(push.n == 2'd2 && push.r1.result_kind == KindSummary) ||
			(push.n == 2'd1 && push.r0.result_kind == KindSummary))
		else $error("end transaction without closing summary");

endmodule

`default_nettype wire

@@ design/gww_queue.sv @@
// Three-entry result queue taking up to two results per cycle.
`default_nettype none

module gww_queue import gww_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire gww_push_t push,
	input  wire logic      pop,
	output gww_out_t       head,
	output logic           nonempty,
	output logic           room_for_two
);

	gww_out_t   entry_q [QueueDepth];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] count_q;

	function automatic logic [1:0] inc3(logic [1:0] p);
		return (p == 2'(QueueDepth - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	assign head         = entry_q[rd_q];
	assign nonempty     = (count_q != 2'd0);
	assign room_for_two = (count_q < 2'd2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry_q[inc3(wr_q)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 2'd0;
		end else begin
			unique case (push.n)
				2'd1:    wr_q <= inc3(wr_q);
				2'd2:    wr_q <= inc3(inc3(wr_q));
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= inc3(rd_q);
			end
			count_q <= count_q + push.n - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) + 32'(push.n) - 32'(pop)) <= QueueDepth)
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("result queue underflow");

endmodule

`default_nettype wire

@@ tb/sv/greedy_word_wrap_unit_tb.sv @@
// Self-checking testbench for the greedy word wrap unit: directed and random text, line checks.
`timescale 1ns / 100ps

module greedy_word_wrap_unit_tb import gww_pkg::*; ();

	localparam int CycleLimit = 20_000_000;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic [7:0] cfg_wdata  = 8'd0;
	logic       char_valid = 1'b0;
	gww_in_t    char_data  = '0;
	logic       line_stall = 1'b0;
	logic       char_stall;
	logic       line_valid;
	gww_out_t   line_data;

	gww_in_t  pending_chars[$];
	gww_out_t expected_lines[$];
	gww_out_t step_res[0:1];
	int       step_n;

	logic [7:0]  width_reg   = BoxWidthRst;
	logic [15:0] pos_next    = 16'd0;
	logic [15:0] line_origin = 16'd0;
	logic [7:0]  fill        = 8'd0;
	logic        space_valid = 1'b0;
	logic [7:0]  space_pos   = 8'd0;
	logic [16:0] line_count  = 17'd0;

	int error_count = 0;
	int cycle_count = 0;
	int send_gap    = 0;
	int recv_gap    = 0;
	bit calm        = 1'b0;

	greedy_word_wrap_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.line_valid (line_valid),
		.line_stall (line_stall),
		.line_data  (line_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] clip_pos(logic [15:0] a, logic [8:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {8'd0, b};
		return (s > TextCap) ? TextCap[15:0] : s[15:0];
	endfunction

	task automatic note_line(logic [15:0] start, logic [7:0] len);
		step_res[step_n] = '{KindLine, start, len, 17'd0, 1'b0};
		step_n++;
		if (line_count < LinesCap)
			line_count++;
	endtask

	task automatic wrap_predict(gww_in_t item);
		int w;
		int cut;
		int skip;
		step_n = 0;
		w = (width_reg == 8'd0) ? 1 : int'(width_reg);
		if (w > MaxWidth)
			w = MaxWidth;
		if (item.end_of_text) begin
			if (fill != 8'd0 || line_count == 17'd0)
				note_line(line_origin, fill);
			step_res[step_n] = '{KindSummary, 16'd0, 8'd0, line_count, 1'b0};
			step_n++;
			pos_next    = 16'd0;
			line_origin = 16'd0;
			fill        = 8'd0;
			space_valid = 1'b0;
			space_pos   = 8'd0;
			line_count  = 17'd0;
		end else begin
			if (item.character != ChNewline && int'(fill) >= w) begin
				skip = (space_valid && space_pos != 8'd0) ? 1 : 0;
				cut  = skip ? int'(space_pos) : w;
				note_line(line_origin, 8'(cut));
				line_origin = clip_pos(line_origin, 9'(cut + skip));
				fill        = 8'(int'(fill) - cut - skip);
				space_valid = 1'b0;
				space_pos   = 8'd0;
			end
			if (item.character == ChNewline) begin
				note_line(line_origin, fill);
				line_origin = clip_pos(pos_next, 9'd1);
				fill        = 8'd0;
				space_valid = 1'b0;
				space_pos   = 8'd0;
			end else begin
				if (item.character == ChSpace) begin
					space_valid = 1'b1;
					space_pos   = fill;
				end
				if (fill != FillMax)
					fill++;
			end
			pos_next = clip_pos(pos_next, 9'd1);
		end
		if (step_n > 0)
			step_res[step_n - 1].last_result = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_lines.push_back(step_res[i]);
	endtask

	task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// driver: predict on each accepted transaction, then present the next one
	always @(posedge clk) begin
		logic nv;
		if (arst_n) begin
			if (char_valid && !char_stall)
				wrap_predict(char_data);
			if (!char_valid || !char_stall) begin
				nv = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_chars.size() != 0 && !calm
						&& $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 18);
				end else if (pending_chars.size() != 0) begin
					nv = 1'b1;
					char_data <= pending_chars.pop_front();
				end
				char_valid <= nv;
			end
		end
	end

	// monitor: check each accepted result, then decide the stall for the next cycle
	always @(posedge clk) begin
		gww_out_t want;
		logic ns;
		if (arst_n) begin
			if (line_valid && !line_stall) begin
				if (expected_lines.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual %p",
						$time, line_data);
				end else begin
					want = expected_lines.pop_front();
					check_field("result_kind", 17'(want.result_kind),
						17'(line_data.result_kind));
					check_field("line_start", 17'(want.line_start), 17'(line_data.line_start));
					check_field("line_length", 17'(want.line_length),
						17'(line_data.line_length));
					check_field("line_total", want.line_total, line_data.line_total);
					check_field("last_result", 17'(want.last_result),
						17'(line_data.last_result));
				end
			end
			ns = 1'b0;
			if (recv_gap > 0) begin
				recv_gap--;
				ns = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 18);
				ns = 1'b1;
			end
			line_stall <= ns;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sample just after the edge so that the edge's updates have settled
	task automatic wait_drained();
		@(posedge clk);
		#1;
		while (pending_chars.size() != 0 || char_valid || expected_lines.size() != 0
				|| line_valid) begin
			@(posedge clk);
			#1;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_width(logic [7:0] w);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
		width_reg = w;
	endtask

	task automatic queue_item(logic [7:0] ch, logic eot);
		pending_chars.push_back('{ch, eot});
	endtask

	task automatic queue_string(string s);
		for (int i = 0; i < s.len(); i++)
			queue_item(s[i], 1'b0);
	endtask

	task automatic random_text(int n, int space_pct, bit close);
		int r;
		logic [7:0] ch;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < space_pct)
				ch = ChSpace;
			else if (r < space_pct + 5)
				ch = ChNewline;
			else if (r < space_pct + 10)
				ch = 8'($urandom_range(0, 255));
			else
				ch = 8'($urandom_range(97, 122));
			queue_item(ch, 1'b0);
		end
		if (close)
			queue_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		logic [7:0] w;
		int pcts[4];
		pcts = '{0, 5, 15, 30};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_width(8'd4);
		queue_item(8'h41, 1'b1);
		queue_string("a");
		queue_item(8'h00, 1'b0);
		queue_string(" cde");
		queue_item(8'hFF, 1'b0);
		queue_string("\n\n xyzw");
		queue_item(8'h00, 1'b1);

		write_width(8'd0);
		queue_string("ab\n");
		queue_item(8'hFF, 1'b1);

		// leave the line open, then shrink the width under it
		write_width(8'd255);
		queue_string("ab cde");
		write_width(8'd2);
		queue_string("qr");
		queue_item(8'h00, 1'b1);

		for (int p = 0; p < 7; p++) begin
			if (p == 0)
				w = 8'd1;
			else if (p == 1)
				w = 8'd255;
			else if (p == 2)
				w = 8'd0;
			else if ($urandom_range(0, 1) == 0)
				w = 8'($urandom_range(2, 12));
			else
				w = 8'($urandom_range(1, 255));
			write_width(w);
			random_text($urandom_range(60, 140), pcts[$urandom_range(0, 3)],
				$urandom_range(0, 3) != 0);
		end

		write_width(8'd70);
		calm = 1'b1;
		random_text(100, 15, 1'b1);

		wait_drained();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
